// ----- rtl/mrb_pkg.sv -----
// Shared constants and types for the maximal rectangle block.
package mrb_pkg;
    localparam int COLS     = 32;
    localparam int MAX_ROWS = 1024;
    localparam int HW       = $clog2(MAX_ROWS + 1);
    localparam int KW       = $clog2(COLS + 1);
    localparam int IW       = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int AW       = 16;

    typedef logic [HW-1:0] t_height;
    typedef logic [AW-1:0] t_area;

    // Broadcast from the sequencer to all lanes.
    typedef struct packed {
        logic          start;
        logic          step;
        logic          mul;
        logic [KW-1:0] k;
        t_height       hk;
    } t_sweep;
endpackage

// ----- rtl/maximal_rectangle_binary_matrix.sv -----
// Top level: maximal all-ones rectangle over a row-streamed binary matrix.
// Per row: the column sweep broadcast to the lanes, a multiply step in the
//   lanes, then the area merge scan; a last row then waits for its result hand-off.
// Rows are taken only in the idle state, so a new row is not taken until the
//   last one is through.
// Reset (synchronous, i_rst_n low): heights and best area cleared,
//   active_columns = 32, no result pending.
// A last row ends with one max_area transfer and clears heights and best area.
module maximal_rectangle_binary_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_row_bits,
    input  logic        i_last_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_max_area
);
    import mrb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [5:0]    r_ncols;
    t_height       r_h [COLS];
    logic          r_last;
    logic [KW-1:0] r_k, n_k;
    t_area         r_best, n_best;
    logic          r_oval;
    t_area         r_oarea;
    t_area         lane_area [COLS];
    t_sweep        sweep;
    logic          acc_in, acc_out;
    logic [6:0]    ncl;

    assign acc_in  = i_valid && !o_stall;
    assign acc_out = r_oval && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;
    assign o_max_area = r_oarea;

    // Active column count, clamped to the lane count.
    assign ncl = (7'(r_ncols) > 7'(COLS)) ? 7'(COLS) : 7'(r_ncols);

    // Broadcast: column k height, zero past the last column to close runs.
    always_comb begin
        sweep.start = acc_in;
        sweep.step  = (r_state == S_SWEEP);
        sweep.mul   = (r_state == S_MUL);
        sweep.k     = r_k;
        sweep.hk    = (r_k < KW'(COLS)) ? r_h[IW'(r_k)] : '0;
    end

    for (genvar j = 0; j < COLS; j++) begin : g_lane
        mrb_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_sweep  (sweep),
            .i_idx    (IW'(j)),
            .i_height (r_h[j]),
            .o_area   (lane_area[j])
        );
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_best  = r_best;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_state = S_SWEEP;
                    n_k     = '0;
                end
            end
            S_SWEEP: begin
                if (r_k == KW'(COLS)) begin
                    n_state = S_MUL;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_MUL: begin
                n_state = S_MERGE;
                n_k     = '0;
            end
            S_MERGE: begin
                if (lane_area[IW'(r_k)] > r_best) n_best = lane_area[IW'(r_k)];
                if (r_k == KW'(COLS - 1)) begin
                    n_state = r_last ? S_DONE : S_IDLE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_DONE: begin
                if (!r_oval || acc_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_best  <= '0;
            r_ncols <= 6'd32;
            r_oval  <= 1'b0;
            r_last  <= 1'b0;
            for (int j = 0; j < COLS; j++) r_h[j] <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_best  <= n_best;
            if (i_cfg_we) r_ncols <= i_cfg_data;
            if (acc_out) r_oval <= 1'b0;
            if (acc_in) begin
                r_last <= i_last_row;
                for (int j = 0; j < COLS; j++) begin
                    if (j < 32 && 7'(j) < ncl && i_row_bits[j % 32]) begin
                        if (r_h[j] < HW'(MAX_ROWS)) r_h[j] <= r_h[j] + HW'(1);
                    end else begin
                        r_h[j] <= '0;
                    end
                end
            end
            // End of matrix: hand off result, clear running state.
            if (r_state == S_DONE && (!r_oval || acc_out)) begin
                r_oval <= 1'b1;
                r_best <= '0;
                for (int j = 0; j < COLS; j++) r_h[j] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_oval || acc_out)) r_oarea <= r_best;
    end

    a_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> (r_state == S_SWEEP) && (r_k == '0))
        else $error("accepted row did not start sweep");
    a_merge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_k < KW'(COLS)))
        else $error("merge index out of range");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_last)
        else $error("result path entered without last row");
endmodule

// ----- rtl/mrb_lane.sv -----
// One lane: widest run of columns at least as tall as its own column.
module mrb_lane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrb_pkg::t_sweep i_sweep,
    input  logic [mrb_pkg::IW-1:0] i_idx,
    input  mrb_pkg::t_height i_height,
    output mrb_pkg::t_area  o_area
);
    import mrb_pkg::*;

    logic [KW-1:0] r_cnt, n_cnt;
    logic          r_in, n_in;
    logic          r_done, n_done;
    logic [KW-1:0] r_wid, n_wid;
    t_area         r_area;
    logic [HW+KW-1:0] prod;

    always_comb begin
        n_cnt  = r_cnt;
        n_in   = r_in;
        n_done = r_done;
        n_wid  = r_wid;
        if (i_sweep.start) begin
            n_cnt  = '0;
            n_in   = 1'b0;
            n_done = 1'b0;
            n_wid  = '0;
        end else if (i_sweep.step && !r_done) begin
            if (i_sweep.hk >= i_height) begin
                n_cnt = r_cnt + KW'(1);
                if (i_sweep.k == KW'(i_idx)) n_in = 1'b1;
            end else if (r_in) begin
                n_done = 1'b1;
                n_wid  = r_cnt;
            end else begin
                n_cnt = '0;
            end
        end
    end

    assign prod = (HW+KW)'(i_height) * (HW+KW)'(r_wid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_in   <= 1'b0;
            r_done <= 1'b0;
            r_wid  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_in   <= n_in;
            r_done <= n_done;
            r_wid  <= n_wid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sweep.mul) begin
            r_area <= (prod > (HW+KW)'(16'hFFFF)) ? 16'hFFFF : AW'(prod);
        end
    end

    assign o_area = r_area;
endmodule

// ----- tb/sv/maximal_rectangle_binary_matrix_chk.sv -----
// Checker for the maximal rectangle block: row predictor and max_area scoreboard.
module maximal_rectangle_binary_matrix_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [31:0] i_row_bits,
    input  logic        i_last_row,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_max_area,
    output int          o_pending,
    output int          o_errors
);
    import mrb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [5:0]  col_count;
    logic [10:0] run_height [COLS];
    logic [15:0] best_so_far;
    logic [15:0] area_fifo [$];
    int          errors;

    assign o_pending = area_fifo.size();
    assign o_errors  = errors;

    // Stack sweep over the current heights, first n columns.
    function automatic int histogram_peak(input int n);
        int stk [COLS+1];
        int top;
        int peak;
        int cur;
        int ht;
        int left;
        top  = 0;
        peak = 0;
        for (int i = 0; i <= n; i++) begin
            cur = (i < n) ? int'(run_height[i]) : 0;
            while (top > 0 && int'(run_height[stk[top-1]]) >= cur) begin
                ht = int'(run_height[stk[top-1]]);
                top--;
                left = (top > 0) ? stk[top-1] + 1 : 0;
                if (ht * (i - left) > peak) peak = ht * (i - left);
            end
            if (i < n) begin
                stk[top] = i;
                top++;
            end
        end
        return peak;
    endfunction

    task automatic take_row(input logic [31:0] bits, input logic last);
        int n;
        int area;
        n = (col_count > COLS) ? COLS : int'(col_count);
        for (int j = 0; j < COLS; j++) begin
            if (j < n && bits[j]) begin
                if (run_height[j] < MAX_ROWS) run_height[j] = run_height[j] + 11'd1;
            end else begin
                run_height[j] = '0;
            end
        end
        area = histogram_peak(n);
        if (area > 65535) area = 65535;
        if (area > best_so_far) best_so_far = area[15:0];
        if (last) begin
            area_fifo.push_back(best_so_far);
            foreach (run_height[j]) run_height[j] = '0;
            best_so_far = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            col_count   = 6'd32;
            best_so_far = '0;
            foreach (run_height[j]) run_height[j] = '0;
            area_fifo.delete();
            errors = 0;
        end else begin
            // result side first; a row cannot yield a result at its own edge
            if (i_out_valid && !i_out_stall) begin
                if (area_fifo.size() == 0) begin
                    $error("max_area: unexpected transfer, actual %0d", i_max_area);
                    errors++;
                end else begin
                    if (i_max_area !== area_fifo[0]) begin
                        $error("max_area: expected %0d, actual %0d",
                               area_fifo[0], i_max_area);
                        errors++;
                    end
                    void'(area_fifo.pop_front());
                end
            end
            // a row taken at this edge still sees the old column count
            if (i_valid && !i_stall_in) take_row(i_row_bits, i_last_row);
            if (i_cfg_we) col_count = i_cfg_data;
        end
    end
endmodule

// ----- tb/sv/maximal_rectangle_binary_matrix_tb.sv -----
// Testbench top: row stimulus, output backpressure and verdict.
module maximal_rectangle_binary_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_row_bits;
    logic        i_last_row;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_max_area;

    int pending;
    int errors;
    int cycles;
    bit quiet;        // no idling on either side in the closing stretch
    bit long_hold;    // request for one long receiver hold-off

    localparam int CYCLE_LIMIT = 500_000;

    maximal_rectangle_binary_matrix dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_row_bits(i_row_bits), .i_last_row(i_last_row),
        .o_valid(o_valid), .i_stall(i_stall), .o_max_area(o_max_area)
    );

    maximal_rectangle_binary_matrix_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_row_bits(i_row_bits), .i_last_row(i_last_row),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_max_area(o_max_area),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int hold;
        hold = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold = 400;
            end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 5);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // One row transfer. o_stall is sampled at the falling edge, where it is stable.
    // Valid stays up after the transfer until an idle gap or drain lowers it; the next row replaces its data.
    task automatic send_row(input logic [31:0] bits, input logic last);
        bit ok;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_row_bits <= bits;
        i_last_row <= last;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // Drain all results, then let a trailing non-last row finish before config.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cols(input logic [5:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random row: dense, sparse or uniform, so rectangles of all sizes show up.
    function automatic logic [31:0] rand_row;
        case ($urandom_range(0, 3))
            0:       return $urandom() | $urandom();
            1:       return $urandom() & $urandom();
            2:       return ~($urandom() & $urandom() & $urandom());
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int rows;
        int items;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_row_bits = '0;
        i_last_row = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset width, full/empty rows, single-row matrix.
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h0F0F_F0F0, 1'b1);
        send_row(32'h0000_0000, 1'b1);
        send_row(32'h8000_0001, 1'b1);
        send_row(32'h5555_5555, 1'b0);
        send_row(32'hAAAA_AAAA, 1'b1);
        // zero columns: every area is 0
        write_cols(6'd0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b1);
        // one column
        write_cols(6'd1);
        send_row(32'hFFFF_FFFE, 1'b0);
        send_row(32'h0000_0001, 1'b0);
        send_row(32'h0000_0001, 1'b1);
        // above COLS behaves as COLS
        write_cols(6'd63);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h7FFF_FFFF, 1'b1);
        write_cols(6'd33);
        send_row(32'hFFFF_FFFF, 1'b1);
        // inactive upper columns read as 0
        write_cols(6'd5);
        send_row(32'hFFFF_FFE0, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b1);
        write_cols(6'd32);

        // Random matrices; the first one runs into a long receiver hold-off.
        long_hold = 1'b1;
        items = 18;
        while (items < 580) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_cols(6'd32);
                    1:       write_cols(6'($urandom_range(0, 3)));
                    default: write_cols(6'($urandom_range(0, 63)));
                endcase
            end
            if (items > 500) quiet = 1'b1;
            rows = $urandom_range(1, 10);
            for (int r = 0; r < rows; r++) begin
                send_row(rand_row(), r == rows - 1);
                items++;
            end
            // stray trailing row without a last marker, picked up by the next matrix
            if ($urandom_range(0, 7) == 0) begin
                send_row(rand_row(), 1'b0);
                items++;
            end
        end
        send_row(rand_row(), 1'b1);

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/mrb_pkg.sv
rtl/mrb_lane.sv
rtl/maximal_rectangle_binary_matrix.sv
tb/sv/maximal_rectangle_binary_matrix_chk.sv
tb/sv/maximal_rectangle_binary_matrix_tb.sv
